FILE: sv/kmrb_pkg.sv
// Shared constants, types and the layout ROM of the key matrix report builder.
package kmrb_pkg;

  localparam int ROWS     = 4;
  localparam int COLUMNS  = 11;
  localparam int MAX_KEYS = 6;

  localparam int ROW_W   = 2;
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 3;
  // Wide enough for a slot count plus the presses of one row.
  localparam int PFX_W   = 5;

  localparam logic [ROW_W-1:0]  LAST_ROW        = ROW_W'(ROWS - 1);
  localparam logic [CODE_W-1:0] CODE_NONE       = 8'd0;
  localparam logic [CODE_W-1:0] CODE_BOOT       = 8'd255;
  localparam logic [CODE_W-1:0] CODE_SHIFT_BASE = 8'd108;
  localparam logic [CODE_W-1:0] CODE_MOD_BASE   = 8'd100;
  localparam logic [CODE_W-1:0] SHIFT_MASK_INIT = 8'd2;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t LAYOUT_ROM [2][ROWS][COLUMNS] = '{
    '{
      '{8'd20, 8'd26, 8'd8, 8'd21, 8'd23, 8'd0, 8'd28, 8'd24, 8'd12, 8'd18, 8'd19},
      '{8'd4, 8'd22, 8'd7, 8'd9, 8'd10, 8'd0, 8'd11, 8'd13, 8'd14, 8'd15, 8'd51},
      '{8'd29, 8'd27, 8'd6, 8'd25, 8'd5, 8'd101, 8'd17, 8'd16, 8'd54, 8'd55, 8'd56},
      '{8'd41, 8'd43, 8'd108, 8'd102, 8'd42, 8'd104, 8'd44, 8'd0, 8'd52, 8'd47, 8'd40}
    },
    '{
      '{8'd138, 8'd139, 8'd153, 8'd154, 8'd157, 8'd0, 8'd75, 8'd36, 8'd37, 8'd38, 8'd145},
      '{8'd140, 8'd141, 8'd146, 8'd147, 8'd53, 8'd0, 8'd78, 8'd33, 8'd34, 8'd35, 8'd154},
      '{8'd142, 8'd143, 8'd45, 8'd46, 8'd161, 8'd101, 8'd49, 8'd30, 8'd31, 8'd32, 8'd155},
      '{8'd255, 8'd181, 8'd108, 8'd102, 8'd0, 8'd104, 8'd0, 8'd0, 8'd55, 8'd39, 8'd48}
    }
  };

endpackage

FILE: sv/kmrb_in_if.sv
// Row item channel of the key matrix report builder.
interface kmrb_in_if import kmrb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_index;
  logic [COLUMNS-1:0] column_bits;
  logic               fn_layer;

  modport source (output valid, row_index, column_bits, fn_layer, input ready);
  modport sink (input valid, row_index, column_bits, fn_layer, output ready);
endinterface

FILE: sv/kmrb_out_if.sv
// Report item channel of the key matrix report builder.
interface kmrb_out_if import kmrb_pkg::*;;
  logic        valid;
  logic        ready;
  logic [7:0]  modifier_byte;
  logic [7:0]  key_slot0;
  logic [7:0]  key_slot1;
  logic [7:0]  key_slot2;
  logic [7:0]  key_slot3;
  logic [7:0]  key_slot4;
  logic [7:0]  key_slot5;
  logic        bootloader_request;

  modport source (output valid, modifier_byte, key_slot0, key_slot1, key_slot2,
                  key_slot3, key_slot4, key_slot5, bootloader_request, input ready);
  modport sink (input valid, modifier_byte, key_slot0, key_slot1, key_slot2,
                key_slot3, key_slot4, key_slot5, bootloader_request, output ready);
endinterface

FILE: sv/kmrb_cfg_if.sv
// Shift mask write channel of the key matrix report builder.
interface kmrb_cfg_if import kmrb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/key_matrix_report_builder_core.sv
// Top level of the key matrix report builder: row scans in, six-key reports out.
//
//  channel  | dir | payload                                         | item
//  ---------+-----+-------------------------------------------------+------------------
//  in_ch    | in  | row_index, column_bits, fn_layer                | one scanned row
//  out_ch   | out | modifier_byte, key_slot0..5, bootloader_request | one report
//  cfg      | in  | data (shift_mask)                               | one register write
//
// A row item is registered, applied to the frame state by one level of per-column
// logic and, for the last row, copied into the report register: one item per cycle.
// The only stall is a last-row item waiting while the report register is full.
// Reset (rst, synchronous) clears the frame and sets shift_mask to 2.
// cfg is always ready; a last row that is taken passes the input register, then the report register.
module key_matrix_report_builder_core import kmrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kmrb_in_if.sink   in_ch,
  kmrb_out_if.source out_ch,
  kmrb_cfg_if.sink  cfg
);

  // Input register.
  logic               s1_valid;
  logic [ROW_W-1:0]   s1_row;
  logic [COLUMNS-1:0] s1_bits;
  logic               s1_layer;
  logic               s1_end;
  logic               s1_go;

  // Frame state.
  logic [CODE_W-1:0]  shift_mask;
  logic [CODE_W-1:0]  modifier_bits;
  code_t              key_store [MAX_KEYS];
  logic [COUNT_W-1:0] key_count;
  logic               boot_flag;

  logic [CODE_W-1:0]  modifier_bits_next;
  code_t              key_store_next [MAX_KEYS];
  logic [COUNT_W-1:0] key_count_next;
  logic               boot_flag_next;

  // Report register.
  logic               out_valid;
  logic [CODE_W-1:0]  out_mod;
  code_t              out_slot [MAX_KEYS];
  logic               out_boot;

  // Per-column decode.
  code_t              col_code  [COLUMNS];
  code_t              col_value [COLUMNS];
  logic [COLUMNS-1:0] col_store;
  logic [COLUMNS-1:0] col_mod;
  logic [COLUMNS-1:0] col_boot;
  logic [COLUMNS-1:0] col_shift;
  logic [COLUMNS-1:0] store_mask;
  logic [COLUMNS-1:0] col_active;
  logic [PFX_W-1:0]   col_pos [COLUMNS];

  assign s1_end = (s1_row == LAST_ROW);
  assign s1_go  = s1_valid && (!s1_end || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_go;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_row   <= in_ch.row_index;
      s1_bits  <= in_ch.column_bits;
      s1_layer <= in_ch.fn_layer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_mask <= SHIFT_MASK_INIT;
    end else if (cfg.valid) begin
      shift_mask <= cfg.data;
    end
  end

  // Each column's place among the row's stored keys is the frame count plus the
  // stored-key presses in lower columns, so every column is settled in parallel.
  always_comb begin
    for (int c = 0; c < COLUMNS; c++) begin
      col_code[c]  = LAYOUT_ROM[s1_layer][s1_row][c];
      col_boot[c]  = (col_code[c] == CODE_BOOT);
      col_shift[c] = (col_code[c] > CODE_SHIFT_BASE) && !col_boot[c];
      col_mod[c]   = (col_code[c] > CODE_MOD_BASE) && (col_code[c] <= CODE_SHIFT_BASE);
      col_store[c] = col_shift[c] || ((col_code[c] != CODE_NONE) &&
                     (col_code[c] <= CODE_MOD_BASE));
      col_value[c] = col_shift[c] ? (col_code[c] - CODE_SHIFT_BASE) : col_code[c];
    end
    store_mask = s1_bits & col_store;
    for (int c = 0; c < COLUMNS; c++) begin
      col_pos[c] = PFX_W'(key_count) +
                   PFX_W'($countones(store_mask & COLUMNS'((1 << c) - 1)));
      col_active[c] = s1_bits[c] && (col_code[c] != CODE_NONE) &&
                      (col_pos[c] < PFX_W'(MAX_KEYS));
    end
  end

  always_comb begin
    modifier_bits_next = modifier_bits;
    boot_flag_next     = boot_flag;
    for (int c = 0; c < COLUMNS; c++) begin
      if (col_active[c] && col_boot[c]) begin
        boot_flag_next = 1'b1;
      end
      if (col_active[c] && col_mod[c]) begin
        modifier_bits_next = modifier_bits_next | (col_code[c] - CODE_MOD_BASE);
      end
      if (col_active[c] && col_shift[c]) begin
        modifier_bits_next = modifier_bits_next | shift_mask;
      end
    end
    // Unfilled slots hold zero, so new keys are simply ORed in at their places.
    for (int s = 0; s < MAX_KEYS; s++) begin
      key_store_next[s] = key_store[s];
      for (int c = 0; c < COLUMNS; c++) begin
        if (col_active[c] && col_store[c] && (col_pos[c] == PFX_W'(s))) begin
          key_store_next[s] = key_store_next[s] | col_value[c];
        end
      end
    end
    key_count_next = key_count + COUNT_W'($countones(col_active & col_store));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_bits <= '0;
      key_count     <= '0;
      boot_flag     <= 1'b0;
      for (int s = 0; s < MAX_KEYS; s++) begin
        key_store[s] <= '0;
      end
    end else if (s1_go) begin
      if (s1_end) begin
        modifier_bits <= '0;
        key_count     <= '0;
        boot_flag     <= 1'b0;
        for (int s = 0; s < MAX_KEYS; s++) begin
          key_store[s] <= '0;
        end
      end else begin
        modifier_bits <= modifier_bits_next;
        key_count     <= key_count_next;
        boot_flag     <= boot_flag_next;
        key_store     <= key_store_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_end) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_end) begin
      out_mod  <= modifier_bits_next;
      out_boot <= boot_flag_next;
      out_slot <= key_store_next;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.modifier_byte      = out_mod;
  assign out_ch.key_slot0          = out_slot[0];
  assign out_ch.key_slot1          = out_slot[1];
  assign out_ch.key_slot2          = out_slot[2];
  assign out_ch.key_slot3          = out_slot[3];
  assign out_ch.key_slot4          = out_slot[4];
  assign out_ch.key_slot5          = out_slot[5];
  assign out_ch.bootloader_request = out_boot;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= COUNT_W'(MAX_KEYS))
    else $error("key count beyond the slot count");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_end |=> out_valid && key_count == '0 && modifier_bits == '0 && !boot_flag)
    else $error("frame end did not give a report and clear the frame");

  a_top_slot_empty: assert property (@(posedge clk) disable iff (rst)
    key_count < COUNT_W'(MAX_KEYS) |-> key_store[MAX_KEYS-1] == '0)
    else $error("slot filled beyond the key count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> s1_valid && s1_end && out_valid && !out_ch.ready)
    else $error("input stalled without a waiting report");

endmodule
